>>> hdl/tes_pkg.sv
// Shared types and constants for the text encoding sniffer.
// Used by every module under hdl; no dependencies.
`default_nettype none

package tes_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register index, taken from paddr above the byte offset bits
    localparam logic REG_CHAR_LIMIT = 1'b0;

    localparam logic [7:0] CHAR_LIMIT_RESET = 8'd100;

    localparam logic [7:0] BOM_UTF8_0 = 8'hEF;
    localparam logic [7:0] BOM_UTF8_1 = 8'hBB;
    localparam logic [7:0] BOM_UTF8_2 = 8'hBF;
    localparam logic [7:0] BOM_FF     = 8'hFF;
    localparam logic [7:0] BOM_FE     = 8'hFE;

    localparam logic [7:0] COUNT_MAX  = 8'hFF;

    typedef enum logic [1:0] {
        ENC_ANSI    = 2'd0,
        ENC_UTF8    = 2'd1,
        ENC_UTF16LE = 2'd2,
        ENC_UTF16BE = 2'd3
    } enc_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        enc_t       encoding;
        logic [1:0] mark_length;
    } out_item_t;

endpackage

`default_nettype wire

>>> hdl/tes_regs.sv
// Configuration register block (APB-style) holding char_limit.
// Depends on tes_pkg.
`default_nettype none

module tes_regs (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [tes_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire  [tes_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tes_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [7:0]                     char_limit
);
    import tes_pkg::*;

    logic [7:0] char_limit_reg;
    logic       reg_index;
    logic       wr_en;

    assign reg_index = paddr[CFG_ADDR_W-1];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready && (reg_index == REG_CHAR_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_limit_reg <= CHAR_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            char_limit_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_CHAR_LIMIT)
        begin
            prdata = {{(CFG_DATA_W-8){1'b0}}, char_limit_reg};
        end
    end

    assign char_limit = char_limit_reg;

endmodule

`default_nettype wire

>>> hdl/tes_scan.sv
// Per-stream sniffer state: mark capture, UTF-8 sequence check, verdict.
// Depends on tes_pkg.
`default_nettype none

module tes_scan (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 step,
    input  tes_pkg::in_item_t   item,
    input  wire  [7:0]          char_limit,
    output tes_pkg::out_item_t  result
);
    import tes_pkg::*;

    logic [1:0]  pos_reg,   pos_next;
    logic [23:0] head_reg,  head_next;
    logic [1:0]  pend_reg,  pend_next;
    logic        valid_reg, valid_next;
    logic        stop_reg,  stop_next;
    logic [7:0]  cnt_reg,   cnt_next;
    logic [7:0]  b;
    logic        ok;

    assign b = item.data_byte;

    always_comb
    begin
        pos_next   = (pos_reg == 2'd3) ? pos_reg : pos_reg + 2'd1;
        head_next  = head_reg;
        pend_next  = pend_reg;
        valid_next = valid_reg;
        stop_next  = stop_reg;
        cnt_next   = cnt_reg;

        case (pos_reg)
            2'd0:    head_next[7:0]   = b;
            2'd1:    head_next[15:8]  = b;
            2'd2:    head_next[23:16] = b;
            default: head_next        = head_reg;
        endcase

        if (!stop_reg)
        begin
            if (pend_reg != 2'd0)
            begin
                if (b[7:6] != 2'b10)
                begin
                    valid_next = 1'b0;
                    stop_next  = 1'b1;
                end
                else
                begin
                    pend_next = pend_reg - 2'd1;
                    if (pend_reg == 2'd1 && cnt_reg != COUNT_MAX)
                    begin
                        cnt_next = cnt_reg + 8'd1;
                    end
                end
            end
            else if (cnt_reg >= char_limit)
            begin
                stop_next = 1'b1;
            end
            else if (b[7])
            begin
                if (b[7:5] == 3'b110)
                begin
                    pend_next = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    pend_next = 2'd2;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    pend_next = 2'd3;
                end
                else
                begin
                    // stray continuation or 11111xxx lead
                    valid_next = 1'b0;
                    stop_next  = 1'b1;
                end
            end
        end
    end

    // verdict as of the byte in hand
    always_comb
    begin
        ok = valid_next && !(!stop_next && pend_next != 2'd0);
        result.encoding    = ENC_ANSI;
        result.mark_length = 2'd0;
        if (pos_next == 2'd3 && head_next[7:0] == BOM_UTF8_0
            && head_next[15:8] == BOM_UTF8_1 && head_next[23:16] == BOM_UTF8_2)
        begin
            result.encoding    = ENC_UTF8;
            result.mark_length = 2'd3;
        end
        else if (pos_next >= 2'd2 && head_next[7:0] == BOM_FF && head_next[15:8] == BOM_FE)
        begin
            result.encoding    = ENC_UTF16LE;
            result.mark_length = 2'd2;
        end
        else if (pos_next >= 2'd2 && head_next[7:0] == BOM_FE && head_next[15:8] == BOM_FF)
        begin
            result.encoding    = ENC_UTF16BE;
            result.mark_length = 2'd2;
        end
        else if (ok && cnt_next != 8'd0)
        begin
            result.encoding = ENC_UTF8;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 2'd0;
            head_reg  <= '0;
            pend_reg  <= 2'd0;
            valid_reg <= 1'b1;
            stop_reg  <= 1'b0;
            cnt_reg   <= 8'd0;
        end
        else if (step)
        begin
            if (item.last)
            begin
                pos_reg   <= 2'd0;
                head_reg  <= '0;
                pend_reg  <= 2'd0;
                valid_reg <= 1'b1;
                stop_reg  <= 1'b0;
                cnt_reg   <= 8'd0;
            end
            else
            begin
                pos_reg   <= pos_next;
                head_reg  <= head_next;
                pend_reg  <= pend_next;
                valid_reg <= valid_next;
                stop_reg  <= stop_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/text_encoding_sniffer.sv
// A last byte is held in the input register, then its verdict is loaded into the result register.
// Throughput: one byte per cycle unless stalled; sniffer state updates once per byte.
// A stalled result holds the next last byte in the input register; other bytes keep flowing.
// Reset (rst_n low, asynchronous): stream state cleared, char_limit back to 100, no valid output.
// Top level; depends on tes_pkg, tes_regs, tes_scan.
`default_nettype none

module text_encoding_sniffer (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_stall,
    input  tes_pkg::in_item_t              in_item,
    output logic                           out_valid,
    input  wire                            out_stall,
    output tes_pkg::out_item_t             out_item,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [tes_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire  [tes_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tes_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import tes_pkg::*;

    logic       s1_valid_reg;
    in_item_t   s1_item_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    out_item_t  scan_result;
    logic [7:0] char_limit;
    logic       out_free;
    logic       s1_move;
    logic       out_load;

    tes_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .char_limit (char_limit)
    );

    tes_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_move),
        .item       (s1_item_reg),
        .char_limit (char_limit),
        .result     (scan_result)
    );

    assign out_free = !out_valid_reg || !out_stall;
    // only a last byte needs room in the result register
    assign s1_move  = s1_valid_reg && (!s1_item_reg.last || out_free);
    assign out_load = s1_move && s1_item_reg.last;
    assign in_stall = s1_valid_reg && !s1_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_item_reg <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= out_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_item_reg <= scan_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_last_waits_for_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_item_reg.last && out_valid_reg && out_stall |-> in_stall)
        else $error("last byte advanced into an occupied result register");

    a_load_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> s1_valid_reg && s1_item_reg.last && out_free)
        else $error("result loaded without a last byte");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s1_item_reg.last && out_valid_reg)
        else $error("input stalled with no pending result");

    a_result_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

`default_nettype wire
